/* sv/yuvab_pkg.sv */
// ----------------------------------------------------------------------------
// YUV 4:2:0 overlay blend - shared definitions
// Field widths, blend constants, the stage load strobes and the
// divide-by-255 helper used by the luma and chroma lanes.
// ----------------------------------------------------------------------------
package yuvab_pkg;

   localparam int unsigned LUMA_LANES = 4;
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned LUMA_W     = LUMA_LANES * PIX_W;
   localparam int unsigned ASUM_W     = 10;
   localparam int unsigned LPROD_W    = 16;
   localparam int unsigned CPROD_W    = 18;
   localparam int unsigned REQ_W      = 128;
   localparam int unsigned RSP_W      = 48;

   localparam logic [PIX_W-1:0]  LUMA_FULL   = 8'd255;
   localparam logic [ASUM_W-1:0] CHROMA_FULL = 10'd1020;

   // Load strobes of the three pipeline stages
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
   } yuvab_adv_type;

   // Exact floor(x / 255) for x up to 255 * 255
   function automatic logic [PIX_W-1:0] div255(input logic [LPROD_W-1:0] x);
      logic [LPROD_W-1:0] t;
      t = x + {8'd0, x[15:8]} + 16'd1;
      return t[15:8];
   endfunction

endpackage

/* sv/yuvab_luma_lane.sv */
// ----------------------------------------------------------------------------
// YUV 4:2:0 overlay blend - luma lane
// Weighted sum of one source and one overlay Y byte in stage 1,
// divided by 255 in stage 2.
// ----------------------------------------------------------------------------
module yuvab_luma_lane (
   input  logic                        clock,
   input  yuvab_pkg::yuvab_adv_type    adv,
   input  logic [7:0]                  src,
   input  logic [7:0]                  ovl,
   input  logic [7:0]                  alpha,
   output logic [7:0]                  blend
);
   import yuvab_pkg::*;

   logic [LPROD_W-1:0] prod_ff, prod_in;
   logic [PIX_W-1:0]   quo_ff, quo_in;
   logic [PIX_W-1:0]   inv_alpha;

   always_comb begin
      inv_alpha = LUMA_FULL - alpha;
      prod_in   = 16'(ovl) * 16'(alpha) + 16'(src) * 16'(inv_alpha);
      quo_in    = div255(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.s1_load) begin
         prod_ff <= prod_in;
      end
      if (adv.s2_load) begin
         quo_ff <= quo_in;
      end
   end

   assign blend = quo_ff;

endmodule

/* sv/yuvab_chroma_lane.sv */
// ----------------------------------------------------------------------------
// YUV 4:2:0 overlay blend - chroma lane
// Weights one chroma pair by the block's alpha sum in stage 2 and
// presents floor(product / 1020) for the output stage.
// ----------------------------------------------------------------------------
module yuvab_chroma_lane (
   input  logic                        clock,
   input  yuvab_pkg::yuvab_adv_type    adv,
   input  logic [7:0]                  src,
   input  logic [7:0]                  ovl,
   input  logic [9:0]                  alpha_sum,
   output logic [7:0]                  blend
);
   import yuvab_pkg::*;

   logic [CPROD_W-1:0] prod_ff, prod_in;
   logic [ASUM_W-1:0]  inv_sum;

   always_comb begin
      inv_sum = CHROMA_FULL - alpha_sum;
      prod_in = 18'(ovl) * 18'(alpha_sum) + 18'(src) * 18'(inv_sum);
   end

   always_ff @(posedge clock) begin
      if (adv.s2_load) begin
         prod_ff <= prod_in;
      end
   end

   // divide by 4, then by 255
   assign blend = div255(prod_ff[CPROD_W-1:2]);

endmodule

/* sv/yuvab_merge.sv */
// ----------------------------------------------------------------------------
// YUV 4:2:0 overlay blend - merge and output stage
// Collects the lane results into one block and picks source or blend.
// ----------------------------------------------------------------------------
module yuvab_merge (
   input  logic                        clock,
   input  yuvab_pkg::yuvab_adv_type    adv,
   input  logic                        enable,
   input  logic [31:0]                 lane_luma,
   input  logic [7:0]                  lane_cb,
   input  logic [7:0]                  lane_cr,
   input  logic [31:0]                 src_luma,
   input  logic [7:0]                  src_cb,
   input  logic [7:0]                  src_cr,
   output logic [47:0]                 data
);
   import yuvab_pkg::*;

   logic [RSP_W-1:0] data_ff, data_in;

   always_comb begin
      if (enable) begin
         data_in = {lane_cr, lane_cb, lane_luma};
      end else begin
         data_in = {src_cr, src_cb, src_luma};
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3_load) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

/* sv/yuv420_alpha_overlay_blend_core.sv */
// ----------------------------------------------------------------------------
// YUV 4:2:0 alpha overlay blend core
// Blends one 2x2 block of an overlay with alpha onto a source frame block.
// ----------------------------------------------------------------------------
// One 2x2 block enters per cycle while the output side keeps up, and its
// result leaves after the three register stages, which are the lane
// products, the luma quotients with the chroma products, and the output
// register. Each stage holds only while the stage after it is full and
// stalled, so a bubble fills even while a result waits. The four luma
// lanes blend independently with their own alpha; chroma uses the sum of
// all four alphas over 1020. With csr_data written to 0 (the reset value)
// the source block passes through. Write csr only while no item is in
// flight.
module yuv420_alpha_overlay_blend_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // source_luma, source_cb, source_cr, overlay_luma, overlay_alpha,
   // overlay_cb, overlay_cr
   input  logic [127:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // blended_luma, blended_cb, blended_cr
   output logic [47:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   // overlay_enable
   input  logic          csr_data
);
   import yuvab_pkg::*;

   logic [LUMA_W-1:0] in_src_luma, in_ovl_luma, in_ovl_alpha;
   logic [PIX_W-1:0]  in_src_cb, in_src_cr, in_ovl_cb, in_ovl_cr;

   logic              enable_ff, enable_in;
   logic              v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic              ready1, ready2, ready3;
   yuvab_adv_type     adv;

   logic [ASUM_W-1:0] asum_ff, asum_in;
   logic              en1_ff, en2_ff;
   logic [LUMA_W-1:0] src_luma1_ff, src_luma2_ff;
   logic [PIX_W-1:0]  src_cb1_ff, src_cr1_ff, ovl_cb1_ff, ovl_cr1_ff;
   logic [PIX_W-1:0]  src_cb2_ff, src_cr2_ff;

   logic [LUMA_W-1:0] lane_luma;
   logic [PIX_W-1:0]  lane_cb, lane_cr;

   assign in_src_luma  = req_tdata[31:0];
   assign in_src_cb    = req_tdata[39:32];
   assign in_src_cr    = req_tdata[47:40];
   assign in_ovl_luma  = req_tdata[79:48];
   assign in_ovl_alpha = req_tdata[111:80];
   assign in_ovl_cb    = req_tdata[119:112];
   assign in_ovl_cr    = req_tdata[127:120];

   // Register write
   assign csr_ready = 1'b1;
   assign enable_in = (csr_valid && csr_ready) ? csr_data : enable_ff;

   // Pipeline flow: a stage loads when it is empty or its successor moves
   always_comb begin
      ready3      = !v3_ff || rsp_tready;
      ready2      = !v2_ff || ready3;
      ready1      = !v1_ff || ready2;
      adv.s1_load = ready1 && req_tvalid;
      adv.s2_load = ready2 && v1_ff;
      adv.s3_load = ready3 && v2_ff;
      v1_in       = ready1 ? req_tvalid : v1_ff;
      v2_in       = ready2 ? v1_ff : v2_ff;
      v3_in       = ready3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
      end
   end

   // Alpha sum of the four lanes feeds both chroma lanes
   assign asum_in = 10'(in_ovl_alpha[7:0])   + 10'(in_ovl_alpha[15:8])
                  + 10'(in_ovl_alpha[23:16]) + 10'(in_ovl_alpha[31:24]);

   always_ff @(posedge clock) begin
      if (adv.s1_load) begin
         asum_ff      <= asum_in;
         en1_ff       <= enable_ff;
         src_luma1_ff <= in_src_luma;
         src_cb1_ff   <= in_src_cb;
         src_cr1_ff   <= in_src_cr;
         ovl_cb1_ff   <= in_ovl_cb;
         ovl_cr1_ff   <= in_ovl_cr;
      end
      if (adv.s2_load) begin
         en2_ff       <= en1_ff;
         src_luma2_ff <= src_luma1_ff;
         src_cb2_ff   <= src_cb1_ff;
         src_cr2_ff   <= src_cr1_ff;
      end
   end

   for (genvar i = 0; i < LUMA_LANES; i++) begin : g_luma
      yuvab_luma_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .src   (in_src_luma[i*PIX_W +: PIX_W]),
         .ovl   (in_ovl_luma[i*PIX_W +: PIX_W]),
         .alpha (in_ovl_alpha[i*PIX_W +: PIX_W]),
         .blend (lane_luma[i*PIX_W +: PIX_W])
      );
   end

   yuvab_chroma_lane u_cb (
      .clock     (clock),
      .adv       (adv),
      .src       (src_cb1_ff),
      .ovl       (ovl_cb1_ff),
      .alpha_sum (asum_ff),
      .blend     (lane_cb)
   );

   yuvab_chroma_lane u_cr (
      .clock     (clock),
      .adv       (adv),
      .src       (src_cr1_ff),
      .ovl       (ovl_cr1_ff),
      .alpha_sum (asum_ff),
      .blend     (lane_cr)
   );

   yuvab_merge u_merge (
      .clock     (clock),
      .adv       (adv),
      .enable    (en2_ff),
      .lane_luma (lane_luma),
      .lane_cb   (lane_cb),
      .lane_cr   (lane_cr),
      .src_luma  (src_luma2_ff),
      .src_cb    (src_cb2_ff),
      .src_cr    (src_cr2_ff),
      .data      (rsp_tdata)
   );

   assign req_tready = ready1;
   assign rsp_tvalid = v3_ff;

endmodule

/* sv/yuvab_checker.sv */
// ----------------------------------------------------------------------------
// YUV 4:2:0 overlay blend - port checker
// Watches the core's ports for flow and latency slips.
// ----------------------------------------------------------------------------
module yuvab_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [47:0]   rsp_tdata
);

   // empty pipeline after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // an empty output stage never blocks the input
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   // an accepted item reaches the output when the output side does not stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tready) ##1 rsp_tready ##1 rsp_tready
         |=> rsp_tvalid)
      else $error("item not delivered after three cycles");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind yuv420_alpha_overlay_blend_core yuvab_checker u_yuvab_checker (.*);

/* tb/yuv420_alpha_overlay_blend_core_test.sv */
// ----------------------------------------------------------------------------
// YUV 4:2:0 alpha overlay blend core - testbench
// Streams 2x2 pixel blocks through the core with the overlay switched on and
// off, predicts each blended block in a local model and checks every result
// field in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module yuv420_alpha_overlay_blend_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import yuvab_pkg::*;

   localparam int unsigned LANE_FULL     = 32'(LUMA_FULL);
   localparam int unsigned SUM_FULL      = 32'(CHROMA_FULL);
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned PIPE_LATENCY  = 3;
   localparam int unsigned REPORT_LIMIT  = 40;

   // Packed from the highest field down so that source_luma lands in bit 0
   typedef struct packed {
      logic [PIX_W-1:0]  overlay_cr;
      logic [PIX_W-1:0]  overlay_cb;
      logic [LUMA_W-1:0] overlay_alpha;
      logic [LUMA_W-1:0] overlay_luma;
      logic [PIX_W-1:0]  source_cr;
      logic [PIX_W-1:0]  source_cb;
      logic [LUMA_W-1:0] source_luma;
   } pixel_block_type;

   typedef struct packed {
      logic [PIX_W-1:0]  blended_cr;
      logic [PIX_W-1:0]  blended_cb;
      logic [LUMA_W-1:0] blended_luma;
   } blended_block_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // source_luma, source_cb, source_cr, overlay_luma, overlay_alpha,
   // overlay_cb, overlay_cr
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // blended_luma, blended_cb, blended_cr
   logic [47:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   // overlay_enable
   logic         csr_data = 1'b0;

   blended_block_type expected_blocks[$];
   bit             overlay_on;
   bit             req_gaps_on;
   bit             rsp_stalls_on;
   int unsigned    mismatch_count;
   int unsigned    blended_items;
   int unsigned    passthrough_items;
   int unsigned    results_checked;
   int unsigned    idle_cycles;
   int unsigned    stall_left;

   yuv420_alpha_overlay_blend_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Blend prediction
   // ------------------------------------------------------------------------
   function automatic int unsigned blend_chroma_sample(int unsigned src, int unsigned ovl,
                                                       int unsigned alpha_sum);
      if (alpha_sum == 0)
         return src;
      if (alpha_sum == SUM_FULL)
         return ovl;
      return (ovl * alpha_sum + src * (SUM_FULL - alpha_sum)) / SUM_FULL;
   endfunction

   function automatic blended_block_type predict_blend(pixel_block_type blk, bit enable);
      blended_block_type res;
      int unsigned    a, s, o, y, alpha_sum;
      int             lane;
      if (!enable) begin
         res.blended_luma = blk.source_luma;
         res.blended_cb   = blk.source_cb;
         res.blended_cr   = blk.source_cr;
         return res;
      end
      alpha_sum = 0;
      for (lane = 0; lane < LUMA_LANES; lane++) begin
         a = 32'(blk.overlay_alpha[lane*PIX_W +: PIX_W]);
         s = 32'(blk.source_luma[lane*PIX_W +: PIX_W]);
         o = 32'(blk.overlay_luma[lane*PIX_W +: PIX_W]);
         if (a == 0)
            y = s;
         else if (a == LANE_FULL)
            y = o;
         else
            y = (o * a + s * (LANE_FULL - a)) / LANE_FULL;
         res.blended_luma[lane*PIX_W +: PIX_W] = y[PIX_W-1:0];
         alpha_sum += a;
      end
      y = blend_chroma_sample(32'(blk.source_cb), 32'(blk.overlay_cb), alpha_sum);
      res.blended_cb = y[PIX_W-1:0];
      y = blend_chroma_sample(32'(blk.source_cr), 32'(blk.overlay_cr), alpha_sum);
      res.blended_cr = y[PIX_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic pixel_block_type make_block(logic [31:0] sy, logic [7:0] su,
                                                  logic [7:0] sv,
                                                  logic [31:0] oy, logic [31:0] oa,
                                                  logic [7:0] ou, logic [7:0] ov);
      pixel_block_type blk;
      blk.source_luma   = sy;
      blk.source_cb     = su;
      blk.source_cr     = sv;
      blk.overlay_luma  = oy;
      blk.overlay_alpha = oa;
      blk.overlay_cb    = ou;
      blk.overlay_cr    = ov;
      return blk;
   endfunction

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] rand_alpha_lane();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h01;
         3: return 8'hFE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Weight toward the pass-through sums and the lane edges
   function automatic logic [31:0] rand_alpha_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2, 3, 4: return {rand_alpha_lane(), rand_alpha_lane(),
                          rand_alpha_lane(), rand_alpha_lane()};
         default: return $urandom;
      endcase
   endfunction

   function automatic pixel_block_type rand_block();
      return make_block({rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel()},
                        rand_pixel(), rand_pixel(),
                        {rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel()},
                        rand_alpha_word(), rand_pixel(), rand_pixel());
   endfunction

   // Mostly back to back, some short gaps, rarely a long one
   function automatic int unsigned rand_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Entered and left at a falling edge; valid stays high between items unless a gap is drawn
   task automatic send_block(pixel_block_type blk);
      int unsigned gap;
      gap = req_gaps_on ? rand_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= blk;
      do @(posedge clock); while (!req_tready);
      expected_blocks.push_back(predict_blend(blk, overlay_on));
      if (overlay_on)
         blended_items++;
      else
         passthrough_items++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_blocks.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_overlay_enable(bit enable);
      wait_for_results();
      repeat (PIPE_LATENCY + 1) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= enable;
      do @(posedge clock); while (!csr_ready);
      overlay_on = enable;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_blocks(int unsigned count, int unsigned pause_every);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         send_block(rand_block());
         if (pause_every != 0 && (i % pause_every) == pause_every - 1)
            wait_for_results();
      end
   endtask

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      if (mismatch_count < REPORT_LIMIT)
         $display("ERROR: result %0d %s: expected %0h, got %0h",
                  results_checked, what, want, got);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Result checking, output stalls and watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      blended_block_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_blocks.size() == 0) begin
            report_mismatch("with nothing pending, data", 64'd0, 64'(got));
         end else begin
            want = expected_blocks.pop_front();
            if (got.blended_luma !== want.blended_luma)
               report_mismatch("blended_luma", 64'(want.blended_luma),
                               64'(got.blended_luma));
            if (got.blended_cb !== want.blended_cb)
               report_mismatch("blended_cb", 64'(want.blended_cb), 64'(got.blended_cb));
            if (got.blended_cr !== want.blended_cr)
               report_mismatch("blended_cr", 64'(want.blended_cr), 64'(got.blended_cr));
         end
         results_checked++;
      end
   end

   always @(negedge clock) begin
      if (!rsp_stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left = rand_gap();
         rsp_tready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) ||
          !(req_tvalid || csr_valid || expected_blocks.size() != 0)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_blocks.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Overlay starts off after reset, so every block is the source block
   task automatic test_reset_default();
      send_block(make_block(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h0000_0000,
                            32'hFFFF_FFFF, 8'h00, 8'h00));
      send_block(make_block(32'h0000_0000, 8'h00, 8'h00, 32'hFFFF_FFFF,
                            32'h8040_2001, 8'hFF, 8'hFF));
      send_block(rand_block());
      send_block(rand_block());
   endtask

   task automatic test_directed_blend();
      write_overlay_enable(1'b1);
      // zero alpha everywhere: source lanes and source chroma
      send_block(make_block(32'h8040_2010, 8'h11, 8'h22, 32'hFFEE_DDCC,
                            32'h0000_0000, 8'hEE, 8'hDD));
      // full alpha everywhere: overlay lanes and overlay chroma
      send_block(make_block(32'h8040_2010, 8'h11, 8'h22, 32'hFFEE_DDCC,
                            32'hFFFF_FFFF, 8'hEE, 8'hDD));
      // smallest blending alpha against extreme pixels
      send_block(make_block(32'hFFFF_FFFF, 8'hFF, 8'h00, 32'h0000_0000,
                            32'h0101_0101, 8'h00, 8'hFF));
      // largest blending alpha against extreme pixels
      send_block(make_block(32'h0000_0000, 8'h00, 8'hFF, 32'hFFFF_FFFF,
                            32'hFEFE_FEFE, 8'hFF, 8'h00));
      // lanes mix zero, full and midway alpha
      send_block(make_block(32'h1234_5678, 8'h40, 8'hC0, 32'h9ABC_DEF0,
                            32'h00FF_0080, 8'hA0, 8'h20));
      // alpha sum one short of full
      send_block(make_block(32'h0000_0000, 8'h00, 8'h00, 32'hFFFF_FFFF,
                            32'hFEFF_FFFF, 8'hFF, 8'hFF));
      // alpha sum of one
      send_block(make_block(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h0000_0000,
                            32'h0000_0001, 8'h00, 8'h00));
      send_block(make_block('1, '1, '1, '1, '1, '1, '1));
      send_block(make_block('0, '0, '0, '0, '0, '0, '0));
      send_block(make_block(32'h0000_0000, 8'h00, 8'hFF, 32'hFFFF_FFFF,
                            32'h8080_8080, 8'hFF, 8'h00));
      send_block(make_block(32'h5555_AAAA, 8'hFF, 8'h00, 32'hAAAA_5555,
                            32'hFF00_0000, 8'h00, 8'hFF));
      send_block(make_block(32'hC3C3_3C3C, 8'h7F, 8'h80, 32'h3C3C_C3C3,
                            32'h7F80_01FE, 8'h80, 8'h7F));
   endtask

   task automatic test_overlay_off();
      write_overlay_enable(1'b0);
      send_block(make_block('1, '1, '1, '0, '1, '0, '0));
      send_block(make_block(32'hA5A5_5A5A, 8'h5A, 8'hA5, 32'h5A5A_A5A5,
                            32'h7F7F_7F7F, 8'hA5, 8'h5A));
      send_random_blocks(150, 0);
   endtask

   task automatic test_random_blend();
      write_overlay_enable(1'b1);
      send_random_blocks(450, 0);
   endtask

   // Let the pipeline run dry between bursts
   task automatic test_drain_pauses();
      send_random_blocks(200, 25);
   endtask

   task automatic test_back_to_back();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_random_blocks(120, 0);
      rsp_stalls_on = 1'b1;
      send_random_blocks(80, 0);
      req_gaps_on   = 1'b1;
   endtask

   task automatic test_setting_changes();
      int unsigned p;
      for (p = 0; p < 6; p++) begin
         write_overlay_enable(1'($urandom_range(0, 1)));
         req_gaps_on   = $urandom_range(0, 3) != 0;
         rsp_stalls_on = $urandom_range(0, 3) != 0;
         send_random_blocks(50, 0);
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      overlay_on    = 1'b0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_default();
      test_directed_blend();
      test_overlay_off();
      test_random_blend();
      test_drain_pauses();
      test_back_to_back();
      test_setting_changes();

      wait_for_results();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (expected_blocks.size() != 0)
         report_mismatch("left outstanding, count", 64'd0, 64'(expected_blocks.size()));

      $display("Checked %0d results: %0d blocks blended, %0d passed through",
               results_checked, blended_items, passthrough_items);
      $display("Covered edge alphas, alpha sums 0 and 1020, overlay on and off, %0d errors",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
